/* rtl/core/jac_pkg.sv */
// Shared types, constants and helper functions for the seven-joint Jacobian unit.
// Used by jac_front, jac_fifo, jac_back and the top level; depends on nothing.
package jac_pkg;

	localparam int NJ = 7;

	typedef logic signed [27:0] q_t;
	typedef logic signed [31:0] zang_t;
	typedef logic signed [31:0] pos_t;
	typedef logic signed [28:0] opa_t;
	typedef logic signed [29:0] opb_t;
	typedef logic signed [58:0] prod_t;
	typedef logic signed [60:0] sum_t;
	typedef logic signed [23:0] out_t;

	typedef struct packed {
		q_t [NJ-1:0] c;
		q_t [NJ-1:0] s;
	} sc_t;

	localparam q_t    CORDIC_GAIN = 28'sd10188014;
	localparam q_t    Q_ONE       = 28'sd16777216;
	localparam zang_t Q_PI        = 32'sd52707179;
	localparam zang_t Q_HALF_PI   = 32'sd26353589;
	localparam logic [4:0] CORDIC_LAST = 5'd23;

	localparam opb_t OFF_BASE_Z = 30'sd2623957;
	localparam opb_t OFF_0054   = 30'sd90597;
	localparam opb_t OFF_1284   = 30'sd2154195;
	localparam opb_t OFF_2104   = 30'sd3529926;
	localparam opb_t OFF_0064   = 30'sd107374;
	localparam opb_t OFF_2084   = 30'sd3496372;
	localparam opb_t OFF_1059   = 30'sd1776707;
	localparam opb_t TOOL_Z     = 30'sd998244;

	localparam sum_t OUT_MAX = 61'sd8388607;
	localparam sum_t OUT_MIN = -61'sd8388608;

	// Arctangent of 2^-i in Q24; from step 9 on it equals 2^(24-i).
	function automatic q_t atan_step(input logic [4:0] i);
		q_t r;
		unique case (i)
			5'd0: r = 28'sd13176795;
			5'd1: r = 28'sd7778716;
			5'd2: r = 28'sd4110060;
			5'd3: r = 28'sd2086331;
			5'd4: r = 28'sd1047214;
			5'd5: r = 28'sd524117;
			5'd6: r = 28'sd262123;
			5'd7: r = 28'sd131069;
			5'd8: r = 28'sd65536;
			default: r = Q_ONE >>> i;
		endcase
		return r;
	endfunction

	function automatic opb_t link_off(input logic [2:0] j, input logic [1:0] k);
		opb_t y;
		opb_t z;
		y = '0;
		z = '0;
		unique case (j)
			3'd0: z = OFF_BASE_Z;
			3'd1: begin y = OFF_0054; z = -OFF_1284; end
			3'd2: begin y = -OFF_2104; z = -OFF_0064; end
			3'd3: begin y = OFF_0064; z = -OFF_2104; end
			3'd4: begin y = -OFF_2084; z = -OFF_0064; end
			3'd5: z = -OFF_1059;
			default: y = -OFF_1059;
		endcase
		if (k == 2'd1) return y;
		if (k == 2'd2) return z;
		return '0;
	endfunction

	// Element (k, b) of the joint rotation built around Rz(angle).
	function automatic opb_t rot_elem(input logic [2:0] j, input logic [1:0] k,
			input logic [1:0] b, input q_t c, input q_t s);
		opb_t ce;
		opb_t se;
		opb_t one;
		opb_t r;
		ce = $signed({{2{c[27]}}, c});
		se = $signed({{2{s[27]}}, s});
		one = $signed({{2{Q_ONE[27]}}, Q_ONE});
		r = '0;
		if (k == 2'd0) begin
			if (b == 2'd0) r = ce;
			else if (b == 2'd1) r = -se;
		end else if (j == 3'd0) begin
			if (k == 2'd1 && b == 2'd0) r = -se;
			else if (k == 2'd1 && b == 2'd1) r = -ce;
			else if (k == 2'd2 && b == 2'd2) r = -one;
		end else if (j[0]) begin
			if (k == 2'd1 && b == 2'd2) r = -one;
			else if (k == 2'd2 && b == 2'd0) r = se;
			else if (k == 2'd2 && b == 2'd1) r = ce;
		end else begin
			if (k == 2'd1 && b == 2'd2) r = one;
			else if (k == 2'd2 && b == 2'd0) r = -se;
			else if (k == 2'd2 && b == 2'd1) r = -ce;
		end
		return r;
	endfunction

	function automatic out_t sat24(input sum_t v);
		if (v > OUT_MAX) return out_t'(24'sh7FFFFF);
		if (v < OUT_MIN) return out_t'(24'sh800000);
		return v[23:0];
	endfunction

endpackage

/* rtl/core/jac_front.sv */
// Front end: takes one beat of seven joint angles and runs seven CORDIC lanes.
// Depends on jac_pkg; hands sine and cosine of every joint to the queue.
module jac_front import jac_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] joint_angle_0,
	input  logic [15:0] joint_angle_1,
	input  logic [15:0] joint_angle_2,
	input  logic [15:0] joint_angle_3,
	input  logic [15:0] joint_angle_4,
	input  logic [15:0] joint_angle_5,
	input  logic [15:0] joint_angle_6,
	output logic        push,
	output sc_t         push_data,
	input  logic        full
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  iter_q;
	q_t          x_q [0:NJ-1];
	q_t          y_q [0:NJ-1];
	zang_t       z_q [0:NJ-1];
	logic        neg_q [0:NJ-1];
	logic [15:0] ang [0:NJ-1];
	logic        accept;
	q_t          step;

	assign ang[0] = joint_angle_0;
	assign ang[1] = joint_angle_1;
	assign ang[2] = joint_angle_2;
	assign ang[3] = joint_angle_3;
	assign ang[4] = joint_angle_4;
	assign ang[5] = joint_angle_5;
	assign ang[6] = joint_angle_6;

	assign in_stall = busy_q;
	assign accept = in_valid && !busy_q;
	assign push = done_q && !full;
	assign step = atan_step(iter_q);

	always_comb begin
		push_data = '0;
		for (int l = 0; l < NJ; l++) begin
			push_data.c[l] = neg_q[l] ? -x_q[l] : x_q[l];
			push_data.s[l] = neg_q[l] ? -y_q[l] : y_q[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			iter_q <= '0;
		end else if (busy_q && !done_q) begin
			iter_q <= iter_q + 5'd1;
			if (iter_q == CORDIC_LAST) done_q <= 1'b1;
		end else if (push) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end
	end

	// Angles past a quarter turn are folded by a half turn; the result is negated at the end.
	always_ff @(posedge clk) begin
		for (int l = 0; l < NJ; l++) begin
			zang_t ze;
			ze = $signed({{5{ang[l][15]}}, ang[l], 11'b0});
			if (accept) begin
				x_q[l] <= CORDIC_GAIN;
				y_q[l] <= '0;
				if (ze > Q_HALF_PI) begin
					z_q[l] <= ze - Q_PI;
					neg_q[l] <= 1'b1;
				end else if (ze < -Q_HALF_PI) begin
					z_q[l] <= ze + Q_PI;
					neg_q[l] <= 1'b1;
				end else begin
					z_q[l] <= ze;
					neg_q[l] <= 1'b0;
				end
			end else if (busy_q && !done_q) begin
				if (!z_q[l][31]) begin
					x_q[l] <= x_q[l] - (y_q[l] >>> iter_q);
					y_q[l] <= y_q[l] + (x_q[l] >>> iter_q);
					z_q[l] <= z_q[l] - $signed({{4{step[27]}}, step});
				end else begin
					x_q[l] <= x_q[l] + (y_q[l] >>> iter_q);
					y_q[l] <= y_q[l] - (x_q[l] >>> iter_q);
					z_q[l] <= z_q[l] + $signed({{4{step[27]}}, step});
				end
			end
		end
	end

endmodule

/* rtl/core/jac_fifo.sv */
// Two-entry queue of per-item sine and cosine sets between front and back.
// Depends on jac_pkg for the entry type.
module jac_fifo import jac_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  sc_t  push_data,
	output logic full,
	input  logic pop,
	output sc_t  pop_data,
	output logic empty
);

	sc_t        mem [0:1];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign pop_data = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= push_data;
	end

endmodule

/* rtl/core/jac_back.sv */
// Back end: chains the joint transforms with a three-multiplier dot unit and
// emits one Jacobian column per beat. Depends on jac_pkg.
module jac_back import jac_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        empty,
	output logic        pop,
	input  sc_t         pop_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  column_index,
	output out_t        linear_x,
	output out_t        linear_y,
	output out_t        linear_z,
	output out_t        angular_x,
	output out_t        angular_y,
	output out_t        angular_z,
	output logic        last_column
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHAIN = 3'd1;
	localparam logic [2:0] ST_TOOL  = 3'd2;
	localparam logic [2:0] ST_COL   = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	localparam logic [3:0] OP_ROT_FIRST = 4'd3;
	localparam logic [3:0] OP_ROT_LAST  = 4'd11;
	localparam logic [3:0] OP_VEC_LAST  = 4'd2;
	localparam logic [2:0] J_LAST       = 3'(NJ - 1);

	logic [2:0] state_q;
	logic [2:0] j_q;
	logic [3:0] op_q;
	logic       half_q;
	logic       ov_q;

	sc_t   sc_q;
	q_t    acc_q [0:2][0:2];
	q_t    nxt_q [0:2][0:2];
	pos_t  pos_q [0:2];
	q_t    axis_q [0:NJ-1][0:2];
	pos_t  org_q [0:NJ-1][0:2];
	out_t  lin_q [0:2];
	prod_t prod_s1 [0:2];

	opa_t       a [0:2];
	opb_t       b [0:2];
	opb_t       d [0:2];
	logic [3:0] ridx;
	logic [1:0] row;
	logic [1:0] col;
	sum_t       sum;
	sum_t       r24;
	sum_t       r28;
	logic       out_free;
	logic       load;

	assign pop = (state_q == ST_IDLE) && !empty;
	assign out_free = !ov_q || !out_stall;
	assign load = (state_q == ST_EMIT) && out_free;
	assign out_valid = ov_q;

	// Rotation ops walk the product matrix row by row.
	assign ridx = op_q - OP_ROT_FIRST;
	always_comb begin
		row = 2'd0;
		col = 2'd0;
		unique case (ridx)
			4'd0: begin row = 2'd0; col = 2'd0; end
			4'd1: begin row = 2'd0; col = 2'd1; end
			4'd2: begin row = 2'd0; col = 2'd2; end
			4'd3: begin row = 2'd1; col = 2'd0; end
			4'd4: begin row = 2'd1; col = 2'd1; end
			4'd5: begin row = 2'd1; col = 2'd2; end
			4'd6: begin row = 2'd2; col = 2'd0; end
			4'd7: begin row = 2'd2; col = 2'd1; end
			default: begin row = 2'd2; col = 2'd2; end
		endcase
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic signed [32:0] diff;
			diff = $signed({pos_q[k][31], pos_q[k]}) - $signed({org_q[j_q][k][31], org_q[j_q][k]});
			d[k] = diff[29:0];
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			a[k] = '0;
			b[k] = '0;
		end
		unique case (state_q)
			ST_CHAIN: begin
				for (int k = 0; k < 3; k++) begin
					if (op_q < OP_ROT_FIRST) begin
						a[k] = $signed({acc_q[op_q[1:0]][k][27], acc_q[op_q[1:0]][k]});
						b[k] = link_off(j_q, 2'(k));
					end else begin
						a[k] = $signed({acc_q[row][k][27], acc_q[row][k]});
						b[k] = rot_elem(j_q, 2'(k), col, sc_q.c[j_q], sc_q.s[j_q]);
					end
				end
			end
			ST_TOOL: begin
				for (int k = 0; k < 3; k++)
					a[k] = $signed({acc_q[op_q[1:0]][k][27], acc_q[op_q[1:0]][k]});
				b[2] = -TOOL_Z;
			end
			ST_COL: begin
				// Cross product z x d, one component per op as two products.
				unique case (op_q[1:0])
					2'd0: begin
						a[0] = $signed({axis_q[j_q][1][27], axis_q[j_q][1]}); b[0] = d[2];
						a[1] = $signed({axis_q[j_q][2][27], axis_q[j_q][2]}); b[1] = -d[1];
					end
					2'd1: begin
						a[0] = $signed({axis_q[j_q][2][27], axis_q[j_q][2]}); b[0] = d[0];
						a[1] = $signed({axis_q[j_q][0][27], axis_q[j_q][0]}); b[1] = -d[2];
					end
					default: begin
						a[0] = $signed({axis_q[j_q][0][27], axis_q[j_q][0]}); b[0] = d[1];
						a[1] = $signed({axis_q[j_q][1][27], axis_q[j_q][1]}); b[1] = -d[0];
					end
				endcase
			end
			default: ;
		endcase
	end

	assign sum = $signed({{2{prod_s1[0][58]}}, prod_s1[0]})
		+ $signed({{2{prod_s1[1][58]}}, prod_s1[1]})
		+ $signed({{2{prod_s1[2][58]}}, prod_s1[2]});
	assign r24 = (sum + 61'sd8388608) >>> 24;
	assign r28 = (sum + 61'sd134217728) >>> 28;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			j_q <= '0;
			op_q <= '0;
			half_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (load) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_CHAIN;
						j_q <= '0;
						op_q <= '0;
						half_q <= 1'b0;
					end
				end
				ST_CHAIN: begin
					half_q <= ~half_q;
					if (half_q) begin
						if (op_q == OP_ROT_LAST) begin
							op_q <= '0;
							if (j_q == J_LAST) state_q <= ST_TOOL;
							else j_q <= j_q + 3'd1;
						end else begin
							op_q <= op_q + 4'd1;
						end
					end
				end
				ST_TOOL: begin
					half_q <= ~half_q;
					if (half_q) begin
						if (op_q == OP_VEC_LAST) begin
							op_q <= '0;
							j_q <= '0;
							state_q <= ST_COL;
						end else begin
							op_q <= op_q + 4'd1;
						end
					end
				end
				ST_COL: begin
					half_q <= ~half_q;
					if (half_q) begin
						if (op_q == OP_VEC_LAST) begin
							op_q <= '0;
							state_q <= ST_EMIT;
						end else begin
							op_q <= op_q + 4'd1;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (j_q == J_LAST) begin
							state_q <= ST_IDLE;
						end else begin
							j_q <= j_q + 3'd1;
							state_q <= ST_COL;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sc_q <= pop_data;
			for (int r = 0; r < 3; r++) begin
				pos_q[r] <= '0;
				for (int c = 0; c < 3; c++)
					acc_q[r][c] <= (r == c) ? Q_ONE : '0;
			end
		end
		if (!half_q) begin
			for (int k = 0; k < 3; k++)
				prod_s1[k] <= a[k] * b[k];
		end else begin
			if (state_q == ST_CHAIN && op_q < OP_ROT_FIRST) begin
				pos_q[op_q[1:0]] <= pos_q[op_q[1:0]] + r24[31:0];
			end else if (state_q == ST_CHAIN) begin
				nxt_q[row][col] <= r24[27:0];
				if (op_q == OP_ROT_LAST) begin
					for (int r = 0; r < 3; r++) begin
						for (int c = 0; c < 3; c++)
							acc_q[r][c] <= (r == 2 && c == 2) ? r24[27:0] : nxt_q[r][c];
						org_q[j_q][r] <= pos_q[r];
					end
					axis_q[j_q][0] <= nxt_q[0][2];
					axis_q[j_q][1] <= nxt_q[1][2];
					axis_q[j_q][2] <= r24[27:0];
				end
			end else if (state_q == ST_TOOL) begin
				pos_q[op_q[1:0]] <= pos_q[op_q[1:0]] + r24[31:0];
			end else if (state_q == ST_COL) begin
				lin_q[op_q[1:0]] <= sat24(r28);
			end
		end
		if (load) begin
			column_index <= j_q;
			linear_x <= lin_q[0];
			linear_y <= lin_q[1];
			linear_z <= lin_q[2];
			angular_x <= sat24(($signed({{33{axis_q[j_q][0][27]}}, axis_q[j_q][0]}) + 61'sd8) >>> 4);
			angular_y <= sat24(($signed({{33{axis_q[j_q][1][27]}}, axis_q[j_q][1]}) + 61'sd8) >>> 4);
			angular_z <= sat24(($signed({{33{axis_q[j_q][2][27]}}, axis_q[j_q][2]}) + 61'sd8) >>> 4);
			last_column <= (j_q == J_LAST);
		end
	end

`ifndef SYNTH
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_column == (column_index == J_LAST)))
		else $error("last_column disagrees with column_index");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load && j_q == J_LAST) |=> state_q == ST_IDLE)
		else $error("back end did not return to idle after the last column");
	a_chain_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHAIN |-> (op_q <= OP_ROT_LAST && j_q <= J_LAST))
		else $error("chain sequencer out of range");
`endif

endmodule

/* rtl/core/arm_geometric_jacobian_7dof_unit.sv */
// Geometric Jacobian of a seven-joint arm: seven column beats per input beat.
// Input throughput is set by the back end's shared three-multiplier dot unit, which
// runs 108 dot products per item, each as a multiply step and then a sum step.
// The 24-step CORDIC front end overlaps the previous item through a two-entry queue.
// Reset (arst_n, asynchronous, active low) clears all handshake and sequencer state.
module arm_geometric_jacobian_7dof_unit import jac_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] joint_angle_0,
	input  logic [15:0] joint_angle_1,
	input  logic [15:0] joint_angle_2,
	input  logic [15:0] joint_angle_3,
	input  logic [15:0] joint_angle_4,
	input  logic [15:0] joint_angle_5,
	input  logic [15:0] joint_angle_6,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  column_index,
	output out_t        linear_x,
	output out_t        linear_y,
	output out_t        linear_z,
	output out_t        angular_x,
	output out_t        angular_y,
	output out_t        angular_z,
	output logic        last_column
);

	logic push;
	logic full;
	logic pop;
	logic empty;
	sc_t  push_data;
	sc_t  pop_data;

	jac_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.joint_angle_0(joint_angle_0), .joint_angle_1(joint_angle_1),
		.joint_angle_2(joint_angle_2), .joint_angle_3(joint_angle_3),
		.joint_angle_4(joint_angle_4), .joint_angle_5(joint_angle_5),
		.joint_angle_6(joint_angle_6),
		.push(push), .push_data(push_data), .full(full)
	);

	jac_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(push_data), .full(full),
		.pop(pop), .pop_data(pop_data), .empty(empty)
	);

	jac_back u_back (
		.clk(clk), .arst_n(arst_n),
		.empty(empty), .pop(pop), .pop_data(pop_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.column_index(column_index),
		.linear_x(linear_x), .linear_y(linear_y), .linear_z(linear_z),
		.angular_x(angular_x), .angular_y(angular_y), .angular_z(angular_z),
		.last_column(last_column)
	);

endmodule
